// ===== hdl/sklt_pkg.sv =====
// shared types and constants for the sorted key/value leaf table
// no dependencies; imported by sklt_cell and sorted_key_value_leaf_table
package sklt_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int KEY_BITS    = 64;
    localparam int VALUE_BITS  = 64;
    localparam int NUM_CELLS   = MAX_ENTRIES + 1;
    localparam int CNT_BITS    = $clog2(NUM_CELLS);
    localparam int CFG_BITS    = 6;
    localparam int KIND_BITS   = 3;
    localparam int STAT_BITS   = 3;
    localparam int CIDX_BITS   = 8;

    localparam int S_DATA_BITS = KEY_BITS + VALUE_BITS;
    localparam int RESULT_BITS = STAT_BITS + 2 * KEY_BITS + VALUE_BITS + CNT_BITS;
    localparam int M_DATA_BITS = ((RESULT_BITS + 7) / 8) * 8;
    localparam int PAD_BITS    = M_DATA_BITS - RESULT_BITS;

    localparam logic [KIND_BITS-1:0] KIND_LOOKUP   = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_INSERT   = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_REMOVE   = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_APPEND   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_PUSH     = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_POP_FRONT = 3'd5;
    localparam logic [KIND_BITS-1:0] KIND_POP_BACK = 3'd6;

    localparam logic [STAT_BITS-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_BITS-1:0] STAT_NOT_FOUND = 3'd1;
    localparam logic [STAT_BITS-1:0] STAT_DUPLICATE = 3'd2;
    localparam logic [STAT_BITS-1:0] STAT_SPLIT     = 3'd3;
    localparam logic [STAT_BITS-1:0] STAT_REFUSED   = 3'd4;

    localparam logic [CIDX_BITS-1:0] CFG_MAX_ENTRIES = 8'd0;
    localparam logic [CIDX_BITS-1:0] CFG_SPLIT_KEEP  = 8'd1;

    typedef enum logic [2:0] {
        MODE_HOLD,
        MODE_INSERT,
        MODE_DELETE,
        MODE_APPEND,
        MODE_PUSH,
        MODE_POP
    } cell_mode_t;

    typedef struct packed {
        cell_mode_t            mode;
        logic                  cmp_en;
        logic [CNT_BITS-1:0]   n;
        logic                  tap_sel;
        logic [CNT_BITS-1:0]   tap_idx;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } cell_ctrl_t;

    typedef struct packed {
        logic                  hit;
        logic [KEY_BITS-1:0]   tap_key;
        logic [VALUE_BITS-1:0] tap_value;
    } cell_tap_t;

endpackage

// ===== hdl/sklt_cell.sv =====
// one table slot: holds a key/value pair, compares it with the request key
// and shifts to or from its neighbors; depends on sklt_pkg
module sklt_cell (
    input  logic                           clk,
    input  logic [sklt_pkg::CNT_BITS-1:0]  idx,
    input  sklt_pkg::cell_ctrl_t           ctrl,
    input  logic                           found_in,
    output logic                           found_out,
    input  logic [sklt_pkg::KEY_BITS-1:0]  left_key,
    input  logic [sklt_pkg::VALUE_BITS-1:0] left_value,
    input  logic [sklt_pkg::KEY_BITS-1:0]  right_key,
    input  logic [sklt_pkg::VALUE_BITS-1:0] right_value,
    output logic [sklt_pkg::KEY_BITS-1:0]  key,
    output logic [sklt_pkg::VALUE_BITS-1:0] value,
    output sklt_pkg::cell_tap_t            tap
);
    import sklt_pkg::*;

    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic                  ge_reg;
    logic                  eq_reg;
    logic                  sel;
    logic                  tapped;

    // first slot at or past the search point
    assign sel       = ge_reg & ~found_in;
    assign found_out = found_in | ge_reg;
    assign tapped    = ctrl.tap_sel ? sel : (idx == ctrl.tap_idx);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        unique case (ctrl.mode)
            MODE_INSERT:
            begin
                if (found_in)
                begin
                    key_next   = left_key;
                    value_next = left_value;
                end
                else if (sel)
                begin
                    key_next   = ctrl.key;
                    value_next = ctrl.value;
                end
            end
            MODE_DELETE:
            begin
                if (found_out)
                begin
                    key_next   = right_key;
                    value_next = right_value;
                end
            end
            MODE_APPEND:
            begin
                if (idx == ctrl.n)
                begin
                    key_next   = ctrl.key;
                    value_next = ctrl.value;
                end
            end
            MODE_PUSH:
            begin
                if (idx == '0)
                begin
                    key_next   = ctrl.key;
                    value_next = ctrl.value;
                end
                else
                begin
                    key_next   = left_key;
                    value_next = left_value;
                end
            end
            MODE_POP:
            begin
                key_next   = right_key;
                value_next = right_value;
            end
            default:
            begin
                key_next   = key_reg;
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        if (ctrl.cmp_en)
        begin
            ge_reg <= (idx >= ctrl.n) || (key_reg >= ctrl.key);
            eq_reg <= (idx < ctrl.n) && (key_reg == ctrl.key);
        end
    end

    assign key           = key_reg;
    assign value         = value_reg;
    assign tap.hit       = sel & eq_reg;
    assign tap.tap_key   = tapped ? key_reg : '0;
    assign tap.tap_value = tapped ? value_reg : '0;

endmodule

// ===== hdl/sorted_key_value_leaf_table.sv =====
// sorted key/value leaf table: a row of slot cells plus the sequencer around it
// depends on sklt_pkg and sklt_cell
// an accepted word passes the compare, execute and report steps in order; the report step
// loads the output register, waiting while it is full, and a new word is taken only in idle;
// an insert that splits then emits the entries above the kept ones, one per output word
// reset: table empty, max_entries 32, split_keep 16, no result pending
module sorted_key_value_leaf_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sklt_pkg::S_DATA_BITS-1:0]  s_tdata,   // key, value
    input  logic [sklt_pkg::KIND_BITS-1:0]    s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sklt_pkg::M_DATA_BITS-1:0]  m_tdata,   // status, key_out, value_out, head_key, count
    output logic                              m_tlast,   // last
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sklt_pkg::CIDX_BITS-1:0]    cfg_index,
    input  logic [sklt_pkg::CFG_BITS-1:0]     cfg_data
);
    import sklt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC,
        ST_RESP,
        ST_DRAIN
    } state_t;

    state_t                 state_reg, state_next;
    logic [KIND_BITS-1:0]   kind_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [STAT_BITS-1:0]   status_reg, status_next;
    logic [KEY_BITS-1:0]    kout_reg, kout_next;
    logic [VALUE_BITS-1:0]  vout_reg, vout_next;
    logic [CNT_BITS-1:0]    drain_reg, drain_next;
    logic [CNT_BITS-1:0]    drain_end_reg, drain_end_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [CFG_BITS-1:0]    max_entries_reg;
    logic [CFG_BITS-1:0]    split_keep_reg;

    logic [CNT_BITS-1:0]    cap;
    logic [CNT_BITS-1:0]    keep;
    logic                   out_free;
    logic                   drain_last;
    logic [KEY_BITS-1:0]    head_key;
    cell_mode_t             mode;
    cell_ctrl_t             ctrl;

    logic [KEY_BITS-1:0]    cell_key   [NUM_CELLS];
    logic [VALUE_BITS-1:0]  cell_value [NUM_CELLS];
    logic                   found      [NUM_CELLS+1];
    cell_tap_t              cell_tap   [NUM_CELLS];
    logic                   hit_any;
    logic [KEY_BITS-1:0]    tap_key;
    logic [VALUE_BITS-1:0]  tap_value;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= CFG_BITS'(MAX_ENTRIES);
            split_keep_reg  <= CFG_BITS'(16);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_MAX_ENTRIES)
                max_entries_reg <= cfg_data;
            else if (cfg_index == CFG_SPLIT_KEEP)
                split_keep_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (max_entries_reg < CFG_BITS'(2))
            cap = CNT_BITS'(2);
        else if (max_entries_reg > CFG_BITS'(MAX_ENTRIES))
            cap = CNT_BITS'(MAX_ENTRIES);
        else
            cap = CNT_BITS'(max_entries_reg);

        if (split_keep_reg < CFG_BITS'(1))
            keep = CNT_BITS'(1);
        else if (CNT_BITS'(split_keep_reg) > cap)
            keep = cap;
        else
            keep = CNT_BITS'(split_keep_reg);
    end

    // cell row
    assign found[0] = 1'b0;

    always_comb
    begin
        ctrl.mode    = mode;
        ctrl.cmp_en  = (state_reg == ST_CMP);
        ctrl.n       = count_reg;
        ctrl.tap_sel = (state_reg != ST_DRAIN) && (kind_reg != KIND_POP_FRONT)
                       && (kind_reg != KIND_POP_BACK);
        if (state_reg == ST_DRAIN)
            ctrl.tap_idx = drain_reg;
        else if (kind_reg == KIND_POP_FRONT)
            ctrl.tap_idx = '0;
        else
            ctrl.tap_idx = count_reg - CNT_BITS'(1);
        ctrl.key     = key_reg;
        ctrl.value   = value_reg;
    end

    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   lkey;
        logic [VALUE_BITS-1:0] lvalue;
        logic [KEY_BITS-1:0]   rkey;
        logic [VALUE_BITS-1:0] rvalue;

        if (i == 0)
        begin : g_first
            assign lkey   = '0;
            assign lvalue = '0;
        end
        else
        begin : g_mid
            assign lkey   = cell_key[i-1];
            assign lvalue = cell_value[i-1];
        end

        if (i == NUM_CELLS - 1)
        begin : g_last
            assign rkey   = '0;
            assign rvalue = '0;
        end
        else
        begin : g_inner
            assign rkey   = cell_key[i+1];
            assign rvalue = cell_value[i+1];
        end

        sklt_cell u_cell (
            .clk         (clk),
            .idx         (CNT_BITS'(i)),
            .ctrl        (ctrl),
            .found_in    (found[i]),
            .found_out   (found[i+1]),
            .left_key    (lkey),
            .left_value  (lvalue),
            .right_key   (rkey),
            .right_value (rvalue),
            .key         (cell_key[i]),
            .value       (cell_value[i]),
            .tap         (cell_tap[i])
        );
    end

    always_comb
    begin
        hit_any   = 1'b0;
        tap_key   = '0;
        tap_value = '0;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            hit_any   = hit_any | cell_tap[i].hit;
            tap_key   = tap_key | cell_tap[i].tap_key;
            tap_value = tap_value | cell_tap[i].tap_value;
        end
    end

    // sequencer
    assign out_free   = !m_tvalid_reg || m_tready;
    assign drain_last = (drain_reg == drain_end_reg);
    assign head_key   = (count_reg != '0) ? cell_key[0] : '0;

    always_comb
    begin
        state_next     = state_reg;
        mode           = MODE_HOLD;
        count_next     = count_reg;
        status_next    = status_reg;
        kout_next      = kout_reg;
        vout_next      = vout_reg;
        drain_next     = drain_reg;
        drain_end_next = drain_end_reg;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_CMP;
            end
            ST_CMP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next  = ST_RESP;
                status_next = STAT_OK;
                kout_next   = key_reg;
                vout_next   = '0;
                case (kind_reg) inside
                    KIND_INSERT:
                    begin
                        if (hit_any)
                            status_next = STAT_DUPLICATE;
                        else if (count_reg < cap)
                        begin
                            mode       = MODE_INSERT;
                            count_next = count_reg + CNT_BITS'(1);
                        end
                        else
                        begin
                            mode           = MODE_INSERT;
                            count_next     = keep;
                            drain_next     = keep;
                            drain_end_next = count_reg;
                            state_next     = ST_DRAIN;
                        end
                    end
                    KIND_REMOVE:
                    begin
                        if (hit_any)
                        begin
                            mode       = MODE_DELETE;
                            count_next = count_reg - CNT_BITS'(1);
                            vout_next  = tap_value;
                        end
                        else
                            status_next = STAT_NOT_FOUND;
                    end
                    KIND_APPEND, KIND_PUSH:
                    begin
                        if (count_reg >= cap)
                            status_next = STAT_REFUSED;
                        else
                        begin
                            mode       = (kind_reg == KIND_APPEND) ? MODE_APPEND : MODE_PUSH;
                            count_next = count_reg + CNT_BITS'(1);
                        end
                    end
                    KIND_POP_FRONT, KIND_POP_BACK:
                    begin
                        if (count_reg == '0)
                            status_next = STAT_REFUSED;
                        else
                        begin
                            mode       = (kind_reg == KIND_POP_FRONT) ? MODE_POP : MODE_HOLD;
                            count_next = count_reg - CNT_BITS'(1);
                            kout_next  = tap_key;
                            vout_next  = tap_value;
                        end
                    end
                    default:
                    begin
                        if (hit_any)
                            vout_next = tap_value;
                        else
                            status_next = STAT_NOT_FOUND;
                    end
                endcase
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = {PAD_BITS'(0), count_reg, head_key, vout_reg,
                                     kout_reg, status_reg};
                    state_next    = ST_IDLE;
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = drain_last;
                    m_tdata_next  = {PAD_BITS'(0), count_reg, head_key, tap_value,
                                     tap_key, STAT_SPLIT};
                    drain_next    = drain_reg + CNT_BITS'(1);
                    if (drain_last)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            kind_reg  <= s_tuser;
            key_reg   <= s_tdata[KEY_BITS-1:0];
            value_reg <= s_tdata[S_DATA_BITS-1:KEY_BITS];
        end
        status_reg    <= status_next;
        kout_reg      <= kout_next;
        vout_reg      <= vout_next;
        drain_reg     <= drain_next;
        drain_end_reg <= drain_end_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
